// File: rtl/lsb_steganography_embed_extract_core_macros.svh
// Assertion macros shared by the LSB steganography core.
`ifndef LSB_STEGANOGRAPHY_EMBED_EXTRACT_CORE_MACROS_SVH
`define LSB_STEGANOGRAPHY_EMBED_EXTRACT_CORE_MACROS_SVH

// Implication checked every clock, disabled while in reset.
`define LSBSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock, disabled while in reset.
`define LSBSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lsbse_pkg.sv
// Shared constants and types of the LSB steganography core.
`timescale 1ns / 1ps
package lsbse_pkg;

  localparam int LANES      = 8;
  localparam int BYTE_W     = 8;
  localparam int HDR_BITS   = 32;
  localparam int HDR_GROUPS = HDR_BITS / LANES;
  localparam int GROUP_W    = 25;
  localparam int MSG_W      = 24;
  localparam int IMG_W      = 27;
  localparam int LEN_W      = 29;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic [GROUP_W-1:0] GROUP_MAX = {GROUP_W{1'b1}};
  localparam logic [BYTE_W-1:0]  LSB_CLEAR = 8'hFE;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_MSG_BYTES = 2'd1;
  localparam logic [1:0] REG_IMG_BYTES = 2'd2;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef struct packed {
    logic             rec_valid;
    logic             refused;
    logic [LEN_W-1:0] len_out;
  } status_t;

endpackage

// File: rtl/lsbse_lane.sv
// One byte lane: replaces the LSB of a cover byte with a payload bit.
`timescale 1ns / 1ps
module lsbse_lane (
  input  logic [lsbse_pkg::BYTE_W-1:0] cover_byte,
  input  logic                         embed_en,
  input  logic                         embed_bit,
  output logic [lsbse_pkg::BYTE_W-1:0] stego
);

  assign stego = embed_en ? ((cover_byte & lsbse_pkg::LSB_CLEAR) |
                             lsbse_pkg::BYTE_W'(embed_bit))
                          : cover_byte;

endmodule

// File: rtl/lsbse_ctrl.sv
// Frame control: group counter, length header, capacity check and extract window.
`timescale 1ns / 1ps
`include "lsb_steganography_embed_extract_core_macros.svh"
module lsbse_ctrl #(
  parameter int LANES = lsbse_pkg::LANES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          frame_start,
  input  logic                          mode,
  input  logic [lsbse_pkg::MSG_W-1:0]   msg_bytes,
  input  logic [lsbse_pkg::IMG_W-1:0]   img_bytes,
  input  logic [lsbse_pkg::BYTE_W-1:0]  msg_byte,
  input  logic [LANES-1:0]              lsb_byte,
  output logic                          embed_en,
  output logic [LANES-1:0]              embed_bits,
  output lsbse_pkg::status_t            status
);

  localparam int HG      = lsbse_pkg::HDR_BITS / LANES;
  localparam int HG_W    = (HG > 1) ? $clog2(HG) : 1;
  localparam int GW      = lsbse_pkg::GROUP_W;
  localparam int LW      = lsbse_pkg::LEN_W;
  localparam int IMG_SH  = $clog2(LANES);

  logic [GW-1:0]                    gi_r, gi_nxt, g;
  logic [lsbse_pkg::HDR_BITS-1:0]   hs_r, hs_nxt, hs_cur;
  logic                             refused_r, refused_now;
  logic                             g_zero, hdr_grp, cap_fail, in_msg, in_len, in_img;
  logic [GW-1:0]                    g_m4;
  logic [lsbse_pkg::HDR_BITS-1:0]   len32;
  logic [HG_W-1:0]                  gsel;
  logic [LANES-1:0]                 hdr_chunk;

  assign g      = frame_start ? '0 : gi_r;
  assign g_zero = (g == '0);
  assign hdr_grp = (g < GW'(HG));
  assign g_m4   = g - GW'(HG);
  assign gsel   = g[HG_W-1:0];

  assign len32    = lsbse_pkg::HDR_BITS'({msg_bytes, 3'b000});
  assign cap_fail = ({1'b0, len32[lsbse_pkg::MSG_W+2:0]} + 28'd32) > {1'b0, img_bytes};

  assign refused_now = g_zero ? cap_fail : refused_r;
  assign hs_cur      = g_zero ? '0 : hs_r;

  // header chunk for this group, MSB of the header in lane 0 of group zero
  assign hdr_chunk = LANES'(len32 >> (LANES * (HG - 1 - int'(gsel))));

  assign in_msg = (g_m4 < GW'(msg_bytes));
  assign in_len = (LW'(g_m4) < hs_cur[lsbse_pkg::HDR_BITS-1:3]);
  // (g+1)*LANES <= image_bytes  <=>  g+1 <= image_bytes / LANES
  assign in_img = ({1'b0, g} + (GW+1)'(1)) <= (GW+1)'(img_bytes >> IMG_SH);

  assign embed_en   = (mode == lsbse_pkg::MODE_EMBED) && !refused_now &&
                      (hdr_grp || in_msg);
  assign embed_bits = hdr_grp ? hdr_chunk : LANES'(msg_byte);

  assign hs_nxt = hdr_grp ? {hs_cur[lsbse_pkg::HDR_BITS-LANES-1:0], lsb_byte} : hs_cur;
  assign gi_nxt = (g == lsbse_pkg::GROUP_MAX) ? g : g + GW'(1);

  assign status.rec_valid = (mode == lsbse_pkg::MODE_EXTRACT) && !hdr_grp && in_len && in_img;
  assign status.refused   = (mode == lsbse_pkg::MODE_EMBED) && refused_now;
  assign status.len_out   = (g >= GW'(HG - 1)) ? hs_nxt[lsbse_pkg::HDR_BITS-1:3] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gi_r      <= '0;
      hs_r      <= '0;
      refused_r <= 1'b0;
    end else if (in_fire) begin
      gi_r      <= gi_nxt;
      hs_r      <= hs_nxt;
      refused_r <= refused_now;
    end
  end

  `LSBSE_ASSERT_IMP(a_rec_only_extract, status.rec_valid, mode == lsbse_pkg::MODE_EXTRACT, "recovered byte flagged in embed mode")
  `LSBSE_ASSERT_IMP(a_no_embed_refused, embed_en, !refused_now && mode == lsbse_pkg::MODE_EMBED, "embedding while refused")
  `LSBSE_ASSERT_IMP(a_no_rec_in_header, status.rec_valid, !hdr_grp, "recovered byte during header groups")
  `LSBSE_ASSERT_NEXT(a_frame_restart, in_fire && frame_start, gi_r == GW'(1), "group counter not restarted by frame start")

endmodule

// File: rtl/lsbse_merge.sv
// Merge stage: gathers lane LSBs and holds the result transaction in the output register.
`timescale 1ns / 1ps
module lsbse_merge #(
  parameter int LANES = lsbse_pkg::LANES
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [LANES-1:0][lsbse_pkg::BYTE_W-1:0]  stego,
  input  lsbse_pkg::status_t                       status,
  output logic [LANES-1:0]                         lsb_byte,
  input  logic                                     out_tready,
  output logic                                     out_tvalid,
  output logic [LANES-1:0][lsbse_pkg::BYTE_W-1:0]  stego_r,
  output logic [LANES-1:0]                         rec_r,
  output lsbse_pkg::status_t                       status_r
);

  logic out_valid_r, out_valid_nxt, fire;

  // lane 0 lands in the MSB
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lsb_byte[LANES-1-k] = stego[k][0];
    end
  end

  assign in_tready     = !out_valid_r || out_tready;
  assign fire          = in_tvalid && in_tready;
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      stego_r  <= stego;
      rec_r    <= status.rec_valid ? lsb_byte : '0;
      status_r <= status;
    end
  end

endmodule

// File: rtl/lsb_steganography_embed_extract_core.sv
// Top level of the LSB steganography embed/extract core.
`timescale 1ns / 1ps
// Takes one group of eight cover bytes per clock and returns one result per group,
// in the cycle after acceptance; back-to-back groups run at a full rate of one per clock,
// set by the single output register (in_tready drops only while a held result is
// not being taken).
// Embed mode writes a 32-bit bit-length header into the LSBs of the first four groups,
// then one message byte per group, unless header plus message exceed image_bytes,
// in which case the frame passes through and refused is set. Extract mode rebuilds
// the header and flags one recovered byte per group while in range.
// in_tuser[0] (frame_start) restarts the group counter. Registers: 0 mode,
// 1 message_bytes, 2 image_bytes at byte addresses 0, 4, 8.
module lsb_steganography_embed_extract_core #(
  parameter int LANES = lsbse_pkg::LANES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cover_byte_0..cover_byte_7 (lane 0 lowest), message_byte
  input  logic [LANES*8+7:0]                in_tdata,
  // frame_start
  input  logic [0:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // stego_byte_0..stego_byte_7, recovered_byte, message_length_out, zero pad
  output logic [((LANES*8+8+lsbse_pkg::LEN_W+7)/8)*8-1:0] out_tdata,
  // recovered_valid, refused
  output logic [1:0]                        out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lsbse_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [lsbse_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [lsbse_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);

  localparam int OUT_RAW = LANES * 8 + 8 + lsbse_pkg::LEN_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  logic                            mode_r;
  logic [lsbse_pkg::MSG_W-1:0]     msg_bytes_r;
  logic [lsbse_pkg::IMG_W-1:0]     img_bytes_r;
  logic                            cfg_wr;
  logic                            in_fire;
  logic                            embed_en;
  logic [LANES-1:0]                embed_bits;
  logic [LANES-1:0]                lsb_byte;
  logic [LANES-1:0][7:0]           cover_bytes, stego, stego_r;
  logic [LANES-1:0]                rec_r;
  lsbse_pkg::status_t              status, status_r;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lsbse_pkg::MODE_EMBED;
      msg_bytes_r <= '0;
      img_bytes_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        lsbse_pkg::REG_MODE:      mode_r      <= cfg_pwdata[0];
        lsbse_pkg::REG_MSG_BYTES: msg_bytes_r <= cfg_pwdata[lsbse_pkg::MSG_W-1:0];
        lsbse_pkg::REG_IMG_BYTES: img_bytes_r <= cfg_pwdata[lsbse_pkg::IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      lsbse_pkg::REG_MODE:      cfg_prdata = lsbse_pkg::CFG_DW'(mode_r);
      lsbse_pkg::REG_MSG_BYTES: cfg_prdata = lsbse_pkg::CFG_DW'(msg_bytes_r);
      lsbse_pkg::REG_IMG_BYTES: cfg_prdata = lsbse_pkg::CFG_DW'(img_bytes_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  assign in_fire     = in_tvalid && in_tready;
  assign cover_bytes = in_tdata[LANES*8-1:0];

  lsbse_ctrl #(.LANES(LANES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .frame_start (in_tuser[0]),
    .mode        (mode_r),
    .msg_bytes   (msg_bytes_r),
    .img_bytes   (img_bytes_r),
    .msg_byte    (in_tdata[LANES*8+7:LANES*8]),
    .lsb_byte    (lsb_byte),
    .embed_en    (embed_en),
    .embed_bits  (embed_bits),
    .status      (status)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    lsbse_lane u_lane (
      .cover_byte (cover_bytes[k]),
      .embed_en   (embed_en),
      .embed_bit  (embed_bits[LANES-1-k]),
      .stego      (stego[k])
    );
  end

  lsbse_merge #(.LANES(LANES)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .stego      (stego),
    .status     (status),
    .lsb_byte   (lsb_byte),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stego_r    (stego_r),
    .rec_r      (rec_r),
    .status_r   (status_r)
  );

  assign out_tdata = OUT_W'({status_r.len_out, 8'(rec_r), stego_r});
  assign out_tuser = {status_r.refused, status_r.rec_valid};

endmodule
